// ===== rtl/core/follower_speed_controller_assert.svh =====
// ----------------------------------------------------------------------------
// follower speed controller assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef FOLLOWER_SPEED_CONTROLLER_ASSERT_SVH
`define FOLLOWER_SPEED_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FSC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSC_ASSERT(label, clk, rst, prop, msg)
`define FSC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg
// shared types, widths, fixed-point constants and saturation for the
// follower speed controller
// ----------------------------------------------------------------------------
package fsc_pkg;

   localparam int FRAC_BITS = 12;

   localparam int WORD_W = 16;
   localparam int GAIN_W = 15;
   localparam int DIFF_W = WORD_W + 1;
   localparam int REF_W  = WORD_W + 2;

   // shared multiplier operand and result widths
   localparam int MUL_A_W = 34 - FRAC_BITS;
   localparam int MUL_B_W = DIFF_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int RND_W   = PROD_W - FRAC_BITS;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = WORD_W;

   localparam int QONE        = 1 << FRAC_BITS;
   localparam int C_STOP_MIN  = (7 * QONE + 500) / 1000;
   localparam int C_DECAY     = (4 * QONE + 2) / 5;
   localparam int C_LIN_JUMP  = (QONE + 5) / 10;
   localparam int C_ANG_JUMP  = QONE / 2;
   localparam int C_REF_EXTRA = (15 * QONE + 50) / 100;
   localparam int C_LIN_SCALE = (22 * QONE + 50) / 100;
   localparam int C_ANG_SCALE = (2 * QONE + 2) / 5;

   localparam int WORD_MAX = (1 << (WORD_W - 1)) - 1;
   localparam int WORD_MIN = -(1 << (WORD_W - 1));
   localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(WORD_MAX);
   localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(WORD_MIN);

   localparam logic [GAIN_W-1:0]        RST_DIST_SP    = GAIN_W'(2048);
   localparam logic signed [WORD_W-1:0] RST_OFF_SP     = WORD_W'(0);
   localparam logic [GAIN_W-1:0]        RST_GAIN_FWD   = GAIN_W'(819);
   localparam logic [GAIN_W-1:0]        RST_GAIN_BWD   = GAIN_W'(2867);
   localparam logic [GAIN_W-1:0]        RST_GAIN_TURN  = GAIN_W'(8192);
   localparam logic [GAIN_W-1:0]        RST_ALIGN_TOL  = GAIN_W'(205);
   localparam logic [GAIN_W-1:0]        RST_ARRIVE_TOL = GAIN_W'(614);

   typedef enum logic [1:0] {
      KIND_LOST   = 2'd0,
      KIND_FOLLOW = 2'd1,
      KIND_TURNED = 2'd2
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DIST_SP    = 3'd0,
      CSR_OFF_SP     = 3'd1,
      CSR_GAIN_FWD   = 3'd2,
      CSR_GAIN_BWD   = 3'd3,
      CSR_GAIN_TURN  = 3'd4,
      CSR_ALIGN_TOL  = 3'd5,
      CSR_ARRIVE_TOL = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]        dist_sp;
      logic signed [WORD_W-1:0] off_sp;
      logic [GAIN_W-1:0]        gain_fwd;
      logic [GAIN_W-1:0]        gain_bwd;
      logic [GAIN_W-1:0]        gain_turn;
      logic [GAIN_W-1:0]        align_tol;
      logic [GAIN_W-1:0]        arrive_tol;
   } cfg_type;

   typedef struct packed {
      logic mul_en;
      logic rnd_en;
   } mul_ctl_type;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [RND_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > RND_MAX) begin
         r = WORD_W'(WORD_MAX);
      end else if (v < RND_MIN) begin
         r = WORD_W'(WORD_MIN);
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/fsc_csr.sv =====
// ----------------------------------------------------------------------------
// fsc_csr
// configuration register file, write only, indexed by csr_index
// ----------------------------------------------------------------------------
module fsc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [fsc_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [fsc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output fsc_pkg::cfg_type                  cfg
);
   import fsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DIST_SP:    cfg_in.dist_sp    = csr_wdata[GAIN_W-1:0];
            CSR_OFF_SP:     cfg_in.off_sp     = csr_wdata[WORD_W-1:0];
            CSR_GAIN_FWD:   cfg_in.gain_fwd   = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_BWD:   cfg_in.gain_bwd   = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_TURN:  cfg_in.gain_turn  = csr_wdata[GAIN_W-1:0];
            CSR_ALIGN_TOL:  cfg_in.align_tol  = csr_wdata[GAIN_W-1:0];
            CSR_ARRIVE_TOL: cfg_in.arrive_tol = csr_wdata[GAIN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dist_sp    <= RST_DIST_SP;
         cfg_ff.off_sp     <= RST_OFF_SP;
         cfg_ff.gain_fwd   <= RST_GAIN_FWD;
         cfg_ff.gain_bwd   <= RST_GAIN_BWD;
         cfg_ff.gain_turn  <= RST_GAIN_TURN;
         cfg_ff.align_tol  <= RST_ALIGN_TOL;
         cfg_ff.arrive_tol <= RST_ARRIVE_TOL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/fsc_mul.sv =====
// ----------------------------------------------------------------------------
// fsc_mul
// shared fixed-point multiplier: registered product, then a registered
// round-to-nearest (ties away from zero) shift by FRAC_BITS
// ----------------------------------------------------------------------------
module fsc_mul (
   input  logic                                clock,
   input  fsc_pkg::mul_ctl_type                ctl,
   input  logic signed [fsc_pkg::MUL_A_W-1:0]  op_a,
   input  logic signed [fsc_pkg::MUL_B_W-1:0]  op_b,
   output logic signed [fsc_pkg::RND_W-1:0]    rnd
);
   import fsc_pkg::*;

   localparam logic signed [PROD_W-1:0] HALF_POS = PROD_W'(QONE / 2);
   localparam logic signed [PROD_W-1:0] HALF_NEG = PROD_W'(QONE / 2 - 1);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] biased;
   logic signed [RND_W-1:0]  rnd_ff;
   logic signed [RND_W-1:0]  rnd_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // negative products take half minus one so the floor shift rounds away from zero
   assign biased = prod_ff + (prod_ff[PROD_W-1] ? HALF_NEG : HALF_POS);
   assign rnd_in = biased[PROD_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.rnd_en) begin
         rnd_ff <= rnd_in;
      end
   end

   assign rnd = rnd_ff;

endmodule

// ===== rtl/core/fsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsc_ctrl
// sequencer: captures a word, forms the errors, runs the shared multiplier
// one product at a time, applies jump limits and state updates, and holds
// the result word in an output register
// ----------------------------------------------------------------------------
`include "follower_speed_controller_assert.svh"

module fsc_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  fsc_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic signed [fsc_pkg::WORD_W-1:0]   req_marker_distance,
   input  logic signed [fsc_pkg::WORD_W-1:0]   req_marker_offset,
   input  logic signed [fsc_pkg::WORD_W-1:0]   req_follower_odom_x,
   input  logic signed [fsc_pkg::WORD_W-1:0]   req_leader_heading,
   input  logic signed [fsc_pkg::WORD_W-1:0]   req_follower_heading,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fsc_pkg::WORD_W-1:0]   rsp_linear_speed,
   output logic signed [fsc_pkg::WORD_W-1:0]   rsp_angular_speed,
   output logic                                rsp_reset_follower_odom,
   output logic                                rsp_reset_leader_odom,
   output logic                                rsp_ready_res,
   output fsc_pkg::mul_ctl_type                mul_ctl,
   output logic signed [fsc_pkg::MUL_A_W-1:0]  mul_a,
   output logic signed [fsc_pkg::MUL_B_W-1:0]  mul_b,
   input  logic signed [fsc_pkg::RND_W-1:0]    mul_rnd
);
   import fsc_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_REF  = 7'b0000010,
      ST_PREP = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_RND  = 7'b0010000,
      ST_KEEP = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   localparam logic [1:0] OP_FIRST  = 2'd0;
   localparam logic [1:0] OP_SECOND = 2'd1;
   localparam logic [1:0] OP_THIRD  = 2'd2;
   localparam logic [1:0] OP_FOURTH = 2'd3;

   localparam logic signed [WORD_W-1:0] STOP_MIN_W = WORD_W'(C_STOP_MIN);
   localparam logic signed [DIFF_W-1:0] LIN_JUMP_P = DIFF_W'(C_LIN_JUMP);
   localparam logic signed [DIFF_W-1:0] LIN_JUMP_N = DIFF_W'(-C_LIN_JUMP);
   localparam logic signed [DIFF_W-1:0] ANG_JUMP_P = DIFF_W'(C_ANG_JUMP);
   localparam logic signed [DIFF_W-1:0] ANG_JUMP_N = DIFF_W'(-C_ANG_JUMP);

   function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
      logic [DIFF_W-1:0] r;
      r = (v < 0) ? -v : v;
      return r;
   endfunction

   // control state
   state_type                state_ff, state_in;
   logic [1:0]               op_ff, op_in;
   logic                     captured_ff, captured_in;
   logic                     turn_done_ff, turn_done_in;
   logic signed [WORD_W-1:0] last_lin_ff, last_lin_in;
   logic signed [WORD_W-1:0] last_ang_ff, last_ang_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // working registers
   kind_type                 kind_ff, kind_in;
   logic signed [WORD_W-1:0] md_ff, md_in;
   logic signed [WORD_W-1:0] mo_ff, mo_in;
   logic signed [WORD_W-1:0] ox_ff, ox_in;
   logic signed [WORD_W-1:0] lh_ff, lh_in;
   logic signed [WORD_W-1:0] fh_ff, fh_in;
   logic signed [WORD_W-1:0] ref_ff, ref_in;
   logic signed [DIFF_W-1:0] diff_a_ff, diff_a_in;
   logic signed [DIFF_W-1:0] diff_b_ff, diff_b_in;
   logic                     flag_ff, flag_in;
   logic                     arrived_ff, arrived_in;
   logic                     aligned_ff, aligned_in;
   logic signed [WORD_W-1:0] lin_ff, lin_in;
   logic signed [WORD_W-1:0] ang_ff, ang_in;

   // result word
   logic signed [WORD_W-1:0] rsp_lin_ff, rsp_lin_in;
   logic signed [WORD_W-1:0] rsp_ang_ff, rsp_ang_in;
   logic                     rsp_rf_ff, rsp_rf_in;
   logic                     rsp_rl_ff, rsp_rl_in;
   logic                     rsp_rdy_ff, rsp_rdy_in;

   logic signed [REF_W-1:0]  ref_sum;
   logic signed [WORD_W-1:0] rnd_sat;
   logic signed [DIFF_W-1:0] d_lin;
   logic signed [DIFF_W-1:0] d_ang;
   logic                     jump_lin;
   logic                     jump_ang;
   logic                     out_free;
   logic                     lin_sel;
   logic                     ang_sel;
   logic                     last_op;

   assign ref_sum  = REF_W'(ox_ff) + REF_W'(md_ff) + REF_W'(C_REF_EXTRA);
   assign rnd_sat  = sat_word(mul_rnd);
   assign d_lin    = DIFF_W'(lin_ff) - DIFF_W'(last_lin_ff);
   assign d_ang    = DIFF_W'(ang_ff) - DIFF_W'(last_ang_ff);
   assign jump_lin = (d_lin > LIN_JUMP_P) || (d_lin < LIN_JUMP_N);
   assign jump_ang = (d_ang > ANG_JUMP_P) || (d_ang < ANG_JUMP_N);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // which product lands in the linear or angular result, and which one ends the item
   always_comb begin
      lin_sel = 1'b0;
      ang_sel = 1'b0;
      last_op = 1'b1;
      case (kind_ff)
         KIND_LOST: begin
            lin_sel = 1'b1;
         end
         KIND_FOLLOW: begin
            lin_sel = (op_ff == OP_FIRST);
            ang_sel = (op_ff == OP_SECOND);
            last_op = (op_ff == OP_SECOND);
         end
         KIND_TURNED: begin
            lin_sel = (op_ff == OP_SECOND);
            ang_sel = (op_ff == OP_FOURTH);
            last_op = (op_ff == OP_FOURTH) || ((op_ff == OP_SECOND) && !arrived_ff);
         end
         default: begin
            last_op = 1'b1;
         end
      endcase
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (kind_ff)
         KIND_LOST: begin
            mul_a = MUL_A_W'(last_lin_ff);
            mul_b = MUL_B_W'(C_DECAY);
         end
         KIND_FOLLOW: begin
            if (op_ff == OP_FIRST) begin
               mul_a = MUL_A_W'(diff_a_ff);
               mul_b = diff_a_ff[DIFF_W-1] ? MUL_B_W'(cfg.gain_bwd) : MUL_B_W'(cfg.gain_fwd);
            end else begin
               // offset error is already negated
               mul_a = MUL_A_W'(diff_b_ff);
               mul_b = MUL_B_W'(cfg.gain_turn);
            end
         end
         KIND_TURNED: begin
            case (op_ff)
               OP_FIRST: begin
                  mul_a = MUL_A_W'(diff_a_ff);
                  mul_b = MUL_B_W'(cfg.gain_fwd);
               end
               OP_SECOND: begin
                  mul_a = mul_rnd[MUL_A_W-1:0];
                  mul_b = MUL_B_W'(C_LIN_SCALE);
               end
               OP_THIRD: begin
                  mul_a = MUL_A_W'(diff_b_ff);
                  mul_b = MUL_B_W'(cfg.gain_turn);
               end
               OP_FOURTH: begin
                  mul_a = mul_rnd[MUL_A_W-1:0];
                  mul_b = MUL_B_W'(C_ANG_SCALE);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      captured_in  = captured_ff;
      turn_done_in = turn_done_ff;
      last_lin_in  = last_lin_ff;
      last_ang_in  = last_ang_ff;
      kind_in      = kind_ff;
      md_in        = md_ff;
      mo_in        = mo_ff;
      ox_in        = ox_ff;
      lh_in        = lh_ff;
      fh_in        = fh_ff;
      ref_in       = ref_ff;
      diff_a_in    = diff_a_ff;
      diff_b_in    = diff_b_ff;
      flag_in      = flag_ff;
      arrived_in   = arrived_ff;
      aligned_in   = aligned_ff;
      lin_in       = lin_ff;
      ang_in       = ang_ff;
      rsp_lin_in   = rsp_lin_ff;
      rsp_ang_in   = rsp_ang_ff;
      rsp_rf_in    = rsp_rf_ff;
      rsp_rl_in    = rsp_rl_ff;
      rsp_rdy_in   = rsp_rdy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_ctl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = kind_type'(req_kind);
               md_in    = req_marker_distance;
               mo_in    = req_marker_offset;
               ox_in    = req_follower_odom_x;
               lh_in    = req_leader_heading;
               fh_in    = req_follower_heading;
               op_in    = OP_FIRST;
               state_in = (kind_type'(req_kind) == KIND_TURNED) ? ST_REF : ST_PREP;
            end
         end
         ST_REF: begin
            if (!captured_ff) begin
               ref_in      = sat_word(RND_W'(ref_sum));
               captured_in = 1'b1;
            end
            state_in = ST_PREP;
         end
         ST_PREP: begin
            lin_in = '0;
            ang_in = '0;
            case (kind_ff)
               KIND_LOST: begin
                  flag_in  = (last_lin_ff > STOP_MIN_W);
                  state_in = (last_lin_ff > STOP_MIN_W) ? ST_MUL : ST_FIN;
               end
               KIND_FOLLOW: begin
                  diff_a_in = DIFF_W'(md_ff) - DIFF_W'(cfg.dist_sp);
                  diff_b_in = DIFF_W'(cfg.off_sp) - DIFF_W'(mo_ff);
                  flag_in   = mag_diff(DIFF_W'(mo_ff)) < DIFF_W'(cfg.align_tol);
                  state_in  = ST_MUL;
               end
               KIND_TURNED: begin
                  diff_a_in = DIFF_W'(ref_ff) - DIFF_W'(ox_ff);
                  diff_b_in = DIFF_W'(lh_ff) - DIFF_W'(fh_ff);
                  state_in  = ST_MUL;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_MUL: begin
            mul_ctl.mul_en = 1'b1;
            if (op_ff == OP_FIRST) begin
               arrived_in = mag_diff(diff_a_ff) < DIFF_W'(cfg.arrive_tol);
               aligned_in = mag_diff(diff_b_ff) < DIFF_W'(cfg.align_tol);
            end
            state_in = ST_RND;
         end
         ST_RND: begin
            mul_ctl.rnd_en = 1'b1;
            state_in       = ST_KEEP;
         end
         ST_KEEP: begin
            if (lin_sel) begin
               lin_in = rnd_sat;
            end
            if (ang_sel) begin
               ang_in = rnd_sat;
            end
            if (last_op) begin
               state_in = ST_FIN;
            end else begin
               op_in    = op_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_FIN: begin
            // wait here while the previous word is still unclaimed
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               rsp_lin_in   = '0;
               rsp_ang_in   = '0;
               rsp_rf_in    = 1'b0;
               rsp_rl_in    = 1'b0;
               rsp_rdy_in   = 1'b0;
               case (kind_ff)
                  KIND_LOST: begin
                     if (flag_ff) begin
                        rsp_lin_in  = lin_ff;
                        last_lin_in = lin_ff;
                     end
                  end
                  KIND_FOLLOW: begin
                     rsp_lin_in  = jump_lin ? last_lin_ff : lin_ff;
                     rsp_ang_in  = jump_ang ? last_ang_ff : ang_ff;
                     last_lin_in = jump_lin ? last_lin_ff : lin_ff;
                     last_ang_in = jump_ang ? last_ang_ff : ang_ff;
                     rsp_rf_in   = flag_ff;
                  end
                  KIND_TURNED: begin
                     if (arrived_ff && (turn_done_ff || aligned_ff)) begin
                        rsp_rf_in    = 1'b1;
                        rsp_rl_in    = 1'b1;
                        rsp_rdy_in   = 1'b1;
                        captured_in  = 1'b0;
                        turn_done_in = 1'b0;
                     end else begin
                        rsp_lin_in = lin_ff;
                        rsp_ang_in = ang_ff;
                     end
                  end
                  default: begin
                     rsp_lin_in = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_FIRST;
         captured_ff  <= 1'b0;
         turn_done_ff <= 1'b0;
         last_lin_ff  <= '0;
         last_ang_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         captured_ff  <= captured_in;
         turn_done_ff <= turn_done_in;
         last_lin_ff  <= last_lin_in;
         last_ang_ff  <= last_ang_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      md_ff      <= md_in;
      mo_ff      <= mo_in;
      ox_ff      <= ox_in;
      lh_ff      <= lh_in;
      fh_ff      <= fh_in;
      ref_ff     <= ref_in;
      diff_a_ff  <= diff_a_in;
      diff_b_ff  <= diff_b_in;
      flag_ff    <= flag_in;
      arrived_ff <= arrived_in;
      aligned_ff <= aligned_in;
      lin_ff     <= lin_in;
      ang_ff     <= ang_in;
      rsp_lin_ff <= rsp_lin_in;
      rsp_ang_ff <= rsp_ang_in;
      rsp_rf_ff  <= rsp_rf_in;
      rsp_rl_ff  <= rsp_rl_in;
      rsp_rdy_ff <= rsp_rdy_in;
   end

   assign req_ready               = (state_ff == ST_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_linear_speed        = rsp_lin_ff;
   assign rsp_angular_speed       = rsp_ang_ff;
   assign rsp_reset_follower_odom = rsp_rf_ff;
   assign rsp_reset_leader_odom   = rsp_rl_ff;
   assign rsp_ready_res           = rsp_rdy_ff;

   `FSC_ASSERT(a_fin_waits, clock, reset,
      (state_ff == ST_FIN) && rsp_valid_ff && !rsp_ready |=> state_ff == ST_FIN,
      "result word overwritten while stalled")
   `FSC_ASSERT(a_accept_starts, clock, reset,
      req_valid && req_ready |=> (state_ff == ST_REF) || (state_ff == ST_PREP),
      "accepted word did not start the sequence")
   `FSC_ASSERT(a_ready_res_stops, clock, reset,
      rsp_valid && rsp_ready_res |-> (rsp_linear_speed == '0) &&
         (rsp_angular_speed == '0) && rsp_reset_leader_odom,
      "ready flag without stop")
   `FSC_ASSERT(a_long_chain, clock, reset,
      (op_ff == OP_THIRD) || (op_ff == OP_FOURTH) |-> kind_ff == KIND_TURNED,
      "heading products outside leader turned")
   `FSC_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> (state_ff == ST_IDLE) && !rsp_valid_ff,
      "reset did not return to idle")

endmodule

// ===== rtl/core/follower_speed_controller.sv =====
// ----------------------------------------------------------------------------
// follower_speed_controller
// leader-following speed controller, one result word per sample word
// ----------------------------------------------------------------------------
// usage:
//   req_*  : sample word (kind, marker distance and offset, follower odometry x,
//            leader and follower heading), valid/ready
//   rsp_*  : result word (linear and angular speed in signed Q3.12, odometry
//            reset requests, ready_res), valid/ready
//   csr_*  : write-only register port, csr_index selects the register,
//            written on every edge with csr_write_en high
//   a word is taken only from idle; all products go one at a time through a
//   single multiplier, each in a multiply, a round and a saturate step
//   marker lost below the stop speed and an unused kind use no product,
//   marker lost with decay uses one, follow two, and leader turned two before
//   arrival and four once arrived; the result is registered from the final
//   step once the output register is free
//   the result sits in an output register, so a new word can be taken while
//   it waits; a later result holds in the final step until it is taken
//   reset (synchronous) loads the register defaults, clears the speed history
//   and the captured reference, and drops rsp_valid
// ----------------------------------------------------------------------------
module follower_speed_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic signed [15:0]  req_marker_distance,
   input  logic signed [15:0]  req_marker_offset,
   input  logic signed [15:0]  req_follower_odom_x,
   input  logic signed [15:0]  req_leader_heading,
   input  logic signed [15:0]  req_follower_heading,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_linear_speed,
   output logic signed [15:0]  rsp_angular_speed,
   output logic                rsp_reset_follower_odom,
   output logic                rsp_reset_leader_odom,
   output logic                rsp_ready_res,
   input  logic                csr_write_en,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   import fsc_pkg::*;

   cfg_type                  cfg;
   mul_ctl_type              mul_ctl;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [RND_W-1:0]   mul_rnd;

   fsc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   fsc_mul u_mul (
      .clock (clock),
      .ctl   (mul_ctl),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .rnd   (mul_rnd)
   );

   fsc_ctrl u_ctrl (
      .clock                   (clock),
      .reset                   (reset),
      .cfg                     (cfg),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_kind                (req_kind),
      .req_marker_distance     (req_marker_distance),
      .req_marker_offset       (req_marker_offset),
      .req_follower_odom_x     (req_follower_odom_x),
      .req_leader_heading      (req_leader_heading),
      .req_follower_heading    (req_follower_heading),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_linear_speed        (rsp_linear_speed),
      .rsp_angular_speed       (rsp_angular_speed),
      .rsp_reset_follower_odom (rsp_reset_follower_odom),
      .rsp_reset_leader_odom   (rsp_reset_leader_odom),
      .rsp_ready_res           (rsp_ready_res),
      .mul_ctl                 (mul_ctl),
      .mul_a                   (mul_a),
      .mul_b                   (mul_b),
      .mul_rnd                 (mul_rnd)
   );

endmodule

// ===== test/follower_speed_controller_tb.sv =====
// ----------------------------------------------------------------------------
// follower_speed_controller_tb
// self-checking bench: queued sample words, valid/ready driver with random
// gaps, model prediction on accept, in-order monitor with back-pressure
// ----------------------------------------------------------------------------
module follower_speed_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsc_pkg::*;

   localparam logic [1:0]            KIND_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_NONE    = 3'd7;

   localparam int IDLE_PERCENT   = 35;
   localparam int QUEUE_DEPTH    = 16;
   localparam int MAX_REPORTS    = 10;
   localparam int WATCHDOG_LIMIT = 4000;

   // fixed-point constants rounded to nearest at the block's fraction width
   localparam longint Q_ONE            = longint'(1) << FRAC_BITS;
   localparam longint Q_HALF           = Q_ONE / 2;
   localparam longint SPEED_FLOOR      = (7 * Q_ONE + 500) / 1000;
   localparam longint DECAY_FACTOR     = (4 * Q_ONE + 2) / 5;
   localparam longint LINEAR_STEP_MAX  = (Q_ONE + 5) / 10;
   localparam longint ANGULAR_STEP_MAX = Q_ONE / 2;
   localparam longint REF_MARGIN       = (15 * Q_ONE + 50) / 100;
   localparam longint LINEAR_SCALE     = (22 * Q_ONE + 50) / 100;
   localparam longint TURN_SCALE       = (2 * Q_ONE + 2) / 5;

   localparam cfg_type DEFAULT_CFG = '{15'd2048, 16'sd0, 15'd819, 15'd2867, 15'd8192,
                                       15'd205, 15'd614};
   localparam cfg_type WIDEST_CFG  = '{15'h7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 15'h7fff,
                                       15'h7fff, 15'h7fff};
   localparam cfg_type NARROW_CFG  = '{15'd0, 16'sh8000, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0};

   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] distance;
      logic signed [15:0] offset;
      logic signed [15:0] odom_x;
      logic signed [15:0] lead_head;
      logic signed [15:0] foll_head;
   } sample_type;

   typedef struct packed {
      logic signed [15:0] linear;
      logic signed [15:0] angular;
      logic               reset_follower;
      logic               reset_leader;
      logic               done;
   } command_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = '0;
   logic signed [15:0] req_marker_distance = '0;
   logic signed [15:0] req_marker_offset = '0;
   logic signed [15:0] req_follower_odom_x = '0;
   logic signed [15:0] req_leader_heading = '0;
   logic signed [15:0] req_follower_heading = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_linear_speed;
   logic signed [15:0] rsp_angular_speed;
   logic               rsp_reset_follower_odom;
   logic               rsp_reset_leader_odom;
   logic               rsp_ready_res;
   logic                  csr_write_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sample_type  sample_queue[$];
   command_type expected_commands[$];
   sample_type  in_flight;
   logic        steady = 1'b0;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;

   // controller state as the bench sees it
   cfg_type            ctl_cfg = DEFAULT_CFG;
   logic signed [15:0] prev_linear = '0;
   logic signed [15:0] prev_angular = '0;
   logic signed [15:0] ref_point = '0;
   logic               ref_held = 1'b0;
   logic               heading_matched = 1'b0;

   follower_speed_controller uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic longint fix_mul(longint a, longint b);
      longint p, m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = (m + Q_HALF) >> FRAC_BITS;
      return (p < 0) ? -m : m;
   endfunction

   function automatic logic signed [15:0] clip_word(longint v);
      if (v > WORD_MAX) begin
         return 16'sh7fff;
      end
      if (v < WORD_MIN) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic command_type compute_command(sample_type s);
      command_type c;
      longint      md, mo, ox, lh, fh, lin, ang, zerr, oerr, gain, err, herr;
      logic        arrived;
      md = s.distance;
      mo = s.offset;
      ox = s.odom_x;
      lh = s.lead_head;
      fh = s.foll_head;
      lin = 0;
      ang = 0;
      c = '0;
      if (s.kind == KIND_LOST) begin
         if (prev_linear > SPEED_FLOOR) begin
            lin = clip_word(fix_mul(prev_linear, DECAY_FACTOR));
            prev_linear = lin[15:0];
         end
      end else if (s.kind == KIND_FOLLOW) begin
         zerr = md - longint'(ctl_cfg.dist_sp);
         oerr = mo - longint'(ctl_cfg.off_sp);
         gain = (zerr < 0) ? longint'(ctl_cfg.gain_bwd) : longint'(ctl_cfg.gain_fwd);
         lin = clip_word(fix_mul(zerr, gain));
         ang = clip_word(-fix_mul(longint'(ctl_cfg.gain_turn), oerr));
         // jump limits fall back to the previous command
         if (magnitude(lin - longint'(prev_linear)) > LINEAR_STEP_MAX) begin
            lin = prev_linear;
         end
         if (magnitude(ang - longint'(prev_angular)) > ANGULAR_STEP_MAX) begin
            ang = prev_angular;
         end
         c.reset_follower = magnitude(mo) < longint'(ctl_cfg.align_tol);
         prev_linear = lin[15:0];
         prev_angular = ang[15:0];
      end else if (s.kind == KIND_TURNED) begin
         if (!ref_held) begin
            ref_point = clip_word(ox + md + REF_MARGIN);
            ref_held = 1'b1;
         end
         err = longint'(ref_point) - ox;
         lin = clip_word(fix_mul(fix_mul(err, longint'(ctl_cfg.gain_fwd)), LINEAR_SCALE));
         arrived = magnitude(err) < longint'(ctl_cfg.arrive_tol);
         if (arrived) begin
            herr = lh - fh;
            ang = clip_word(fix_mul(fix_mul(herr, longint'(ctl_cfg.gain_turn)), TURN_SCALE));
            if (magnitude(herr) < longint'(ctl_cfg.align_tol)) begin
               heading_matched = 1'b1;
            end
         end
         if (arrived && heading_matched) begin
            ref_held = 1'b0;
            heading_matched = 1'b0;
            c.reset_follower = 1'b1;
            c.reset_leader = 1'b1;
            c.done = 1'b1;
            lin = 0;
            ang = 0;
         end
      end
      c.linear = lin[15:0];
      c.angular = ang[15:0];
      return c;
   endfunction

   function automatic cfg_type random_settings(logic full);
      cfg_type c;
      if (full) begin
         c.dist_sp = 15'($urandom);
         c.off_sp = 16'($urandom);
         c.gain_fwd = 15'($urandom);
         c.gain_bwd = 15'($urandom);
         c.gain_turn = 15'($urandom);
         c.align_tol = 15'($urandom);
         c.arrive_tol = 15'($urandom);
      end else begin
         c.dist_sp = 15'($urandom_range(12000, 0));
         c.off_sp = 16'(rand_between(-3000, 3000));
         c.gain_fwd = 15'($urandom_range(12000, 1));
         c.gain_bwd = 15'($urandom_range(12000, 1));
         c.gain_turn = 15'($urandom_range(12000, 1));
         c.align_tol = 15'($urandom_range(2000, 50));
         c.arrive_tol = 15'($urandom_range(3000, 100));
      end
      return c;
   endfunction

   // driver: one word at a time, random gaps, predicted on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_commands.push_back(compute_command(in_flight));
         end
         if (!req_valid || req_ready) begin
            if (sample_queue.size() > 0 && (steady || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
               in_flight = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_kind <= in_flight.kind;
               req_marker_distance <= in_flight.distance;
               req_marker_offset <= in_flight.offset;
               req_follower_odom_x <= in_flight.odom_x;
               req_leader_heading <= in_flight.lead_head;
               req_follower_heading <= in_flight.foll_head;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure, in-order compare
   always @(posedge clock) begin : monitor
      command_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_linear_speed, rsp_angular_speed, rsp_reset_follower_odom,
                    rsp_reset_leader_odom, rsp_ready_res};
            if (expected_commands.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected result word: lin %0d ang %0d flags %b%b%b",
                           $signed(got.linear), $signed(got.angular), got.reset_follower,
                           got.reset_leader, got.done);
               end
            end else begin
               want = expected_commands.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("result mismatch: expected lin %0d ang %0d rf %b rl %b rdy %b",
                              $signed(want.linear), $signed(want.angular),
                              want.reset_follower, want.reset_leader, want.done);
                     $display("                 actual   lin %0d ang %0d rf %b rl %b rdy %b",
                              $signed(got.linear), $signed(got.angular),
                              got.reset_follower, got.reset_leader, got.done);
                  end
               end
            end
         end
         rsp_ready <= steady || $urandom_range(99, 0) >= IDLE_PERCENT;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_sample(logic [1:0] kind, int md, int mo, int ox, int lh, int fh);
      sample_type s;
      while (sample_queue.size() >= QUEUE_DEPTH) begin
         @(negedge clock);
      end
      s.kind = kind;
      s.distance = clip_word(md);
      s.offset = clip_word(mo);
      s.odom_x = clip_word(ox);
      s.lead_head = clip_word(lh);
      s.foll_head = clip_word(fh);
      sample_queue.push_back(s);
   endtask

   // checked at the falling edge so the driver's updates have settled
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (sample_queue.size() != 0 || req_valid || expected_commands.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_DIST_SP:    ctl_cfg.dist_sp = data[GAIN_W-1:0];
         CSR_OFF_SP:     ctl_cfg.off_sp = data;
         CSR_GAIN_FWD:   ctl_cfg.gain_fwd = data[GAIN_W-1:0];
         CSR_GAIN_BWD:   ctl_cfg.gain_bwd = data[GAIN_W-1:0];
         CSR_GAIN_TURN:  ctl_cfg.gain_turn = data[GAIN_W-1:0];
         CSR_ALIGN_TOL:  ctl_cfg.align_tol = data[GAIN_W-1:0];
         CSR_ARRIVE_TOL: ctl_cfg.arrive_tol = data[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   // top bit of the 15-bit registers is don't-care, so it is randomized
   task automatic load_settings(cfg_type target);
      wait_idle();
      repeat (20) @(posedge clock);
      write_reg(CSR_DIST_SP, {1'($urandom), target.dist_sp});
      write_reg(CSR_OFF_SP, target.off_sp);
      write_reg(CSR_GAIN_FWD, {1'($urandom), target.gain_fwd});
      write_reg(CSR_GAIN_BWD, {1'($urandom), target.gain_bwd});
      write_reg(CSR_GAIN_TURN, {1'($urandom), target.gain_turn});
      write_reg(CSR_ALIGN_TOL, {1'($urandom), target.align_tol});
      write_reg(CSR_ARRIVE_TOL, {1'($urandom), target.arrive_tol});
      write_reg(CSR_NONE, 16'($urandom));
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(cfg_type settings, int quota, logic calm);
      int queued, pick, len, i, md, mo, ox0, ox, target, lh, herr, tol;
      load_settings(settings);
      steady <= calm;
      queued = 0;
      while (queued < quota) begin
         pick = $urandom_range(99, 0);
         if (pick < 35) begin
            // reach-and-turn manoeuvre, started from a known capture state
            len = $urandom_range(10, 3);
            wait_idle();
            if (!ref_held) begin
               ox0 = rand_between(-10000, 10000);
               md = rand_between(0, 10000);
               target = clip_word(ox0 + md + REF_MARGIN);
            end else begin
               target = ref_point;
               ox0 = target - rand_between(-6000, 6000);
               md = rand_between(WORD_MIN, WORD_MAX);
            end
            lh = rand_between(-20000, 20000);
            tol = int'(ctl_cfg.arrive_tol) / 2;
            for (i = 0; i <= len; i++) begin
               ox = ox0 + (target - ox0) * i / len;
               if (i < len) begin
                  ox += rand_between(-tol, tol);
               end
               if (i == len) begin
                  herr = 0;
               end else if (i >= len - 2) begin
                  herr = rand_between(-int'(ctl_cfg.align_tol), int'(ctl_cfg.align_tol));
               end else begin
                  herr = rand_between(-8000, 8000);
               end
               queue_sample(KIND_TURNED, md, rand_between(WORD_MIN, WORD_MAX), ox, lh,
                            lh - herr);
               md = rand_between(WORD_MIN, WORD_MAX);
            end
            queued += len + 1;
         end else if (pick < 70) begin
            // follow run drifting around the setpoints, slightly forward-biased
            len = $urandom_range(20, 5);
            md = int'(ctl_cfg.dist_sp) + rand_between(-500, 500);
            mo = int'(ctl_cfg.off_sp) + rand_between(-1500, 1500);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(7, 0) == 0) begin
                  md = rand_between(WORD_MIN, WORD_MAX);
                  mo = rand_between(WORD_MIN, WORD_MAX);
               end else begin
                  md = clip_word(md + rand_between(-600, 900));
                  mo = clip_word(mo + rand_between(-250, 250));
               end
               queue_sample(KIND_FOLLOW, md, mo, rand_between(WORD_MIN, WORD_MAX),
                            rand_between(WORD_MIN, WORD_MAX), rand_between(WORD_MIN, WORD_MAX));
            end
            queued += len;
         end else if (pick < 82) begin
            len = $urandom_range(8, 2);
            for (i = 0; i < len; i++) begin
               queue_sample(KIND_LOST, rand_between(WORD_MIN, WORD_MAX),
                            rand_between(WORD_MIN, WORD_MAX), rand_between(WORD_MIN, WORD_MAX),
                            rand_between(WORD_MIN, WORD_MAX), rand_between(WORD_MIN, WORD_MAX));
            end
            queued += len;
         end else begin
            len = $urandom_range(4, 1);
            for (i = 0; i < len; i++) begin
               queue_sample(2'($urandom), rand_between(WORD_MIN, WORD_MAX),
                            rand_between(WORD_MIN, WORD_MAX), rand_between(WORD_MIN, WORD_MAX),
                            rand_between(WORD_MIN, WORD_MAX), rand_between(WORD_MIN, WORD_MAX));
            end
            queued += len;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset register values
      queue_sample(KIND_UNUSED, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
      queue_sample(KIND_LOST, 0, 0, 0, 0, 0);
      queue_sample(KIND_FOLLOW, 3048, 0, 0, 0, 0);
      queue_sample(KIND_FOLLOW, 4048, 100, 0, 0, 0);
      queue_sample(KIND_FOLLOW, 5048, 300, 0, 0, 0);
      // decay of a positive speed while the marker is lost
      queue_sample(KIND_LOST, 0, 0, 0, 0, 0);
      queue_sample(KIND_LOST, 0, 0, 0, 0, 0);
      // large steps are held at the previous command
      queue_sample(KIND_FOLLOW, WORD_MAX, WORD_MAX, 0, 0, 0);
      queue_sample(KIND_FOLLOW, WORD_MIN, WORD_MIN, 0, 0, 0);
      queue_sample(KIND_FOLLOW, 2048, -204, 0, 0, 0);
      queue_sample(KIND_FOLLOW, 1000, 205, 0, 0, 0);
      queue_sample(KIND_FOLLOW, 1500, -205, 0, 0, 0);
      queue_sample(KIND_LOST, 0, 0, 0, 0, 0);
      // manoeuvre: approach, arrive misaligned, then align
      queue_sample(KIND_TURNED, 2048, 0, 0, 0, 0);
      queue_sample(KIND_TURNED, 0, 0, 2500, 1000, 0);
      queue_sample(KIND_TURNED, 0, 0, 2600, 50, 50);
      // saturated reference and heading error at both ends
      queue_sample(KIND_TURNED, WORD_MAX, 0, WORD_MAX, WORD_MAX, WORD_MIN);
      queue_sample(KIND_TURNED, 0, 0, WORD_MAX, WORD_MIN, WORD_MIN);
      queue_sample(KIND_TURNED, WORD_MIN, 0, WORD_MIN, WORD_MIN, WORD_MAX);
      queue_sample(KIND_TURNED, 0, 0, WORD_MIN, WORD_MAX, WORD_MAX);
      // arrival and alignment just inside the tolerances on one word
      queue_sample(KIND_TURNED, 1000, 0, -20000, 0, 0);
      queue_sample(KIND_TURNED, 0, 0, -18386 + 613, 204, 0);
      // error equal to the arrival tolerance does not count as arrived
      queue_sample(KIND_TURNED, 0, 0, 0, 0, 0);
      queue_sample(KIND_TURNED, 0, 0, 1, 7, 7);
      queue_sample(KIND_UNUSED, 0, 0, 0, 0, 0);

      run_phase(DEFAULT_CFG, 200, 1'b0);
      run_phase(random_settings(1'b0), 200, 1'b0);
      run_phase(WIDEST_CFG, 180, 1'b0);
      run_phase(NARROW_CFG, 160, 1'b0);
      run_phase(random_settings(1'b1), 180, 1'b0);
      run_phase(random_settings(1'b0), 200, 1'b0);
      run_phase(DEFAULT_CFG, 200, 1'b1);

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
